>>> design/utf2ucs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package utf2ucs_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CapW    = 15;
  localparam int unsigned UcsW    = 16;
  localparam int unsigned PendW   = 24;
  localparam int unsigned WordW   = PendW + ByteW;

  localparam logic [CapW-1:0] CapReset  = 15'd256;
  localparam logic [CapW-1:0] CharCost  = 15'd4;
  localparam logic [CapW-1:0] MinBudget = 15'd5;

  localparam logic [WordW-1:0] Win1Lo = 32'h0000_0000;
  localparam logic [WordW-1:0] Win1Hi = 32'h0000_007F;
  localparam logic [WordW-1:0] Win2Lo = 32'h0000_C080;
  localparam logic [WordW-1:0] Win2Hi = 32'h0000_DFBF;
  localparam logic [WordW-1:0] Win3Lo = 32'h00E0_8080;
  localparam logic [WordW-1:0] Win3Hi = 32'h00EF_BFBF;
  localparam logic [WordW-1:0] Win4Lo = 32'hF080_8080;
  localparam logic [WordW-1:0] Win4Hi = 32'hF7BF_BFBF;

  localparam logic [1:0] Len1 = 2'd0;
  localparam logic [1:0] Len2 = 2'd1;
  localparam logic [1:0] Len3 = 2'd2;
  localparam logic [1:0] Len4 = 2'd3;

  localparam logic [1:0] DigitLast = 2'd3;

  typedef struct packed {
    logic            valid;
    logic            hex;
    logic            str_end;
    logic            bad;
    logic [UcsW-1:0] ucs;
  } bundle_t;

  function automatic logic [ByteW-1:0] hex_digit(input logic [3:0] v);
    logic [ByteW-1:0] r;
    if (v < 4'd10) begin
      r = 8'h30 + {4'b0, v};
    end else begin
      r = 8'h37 + {4'b0, v};
    end
    return r;
  endfunction

  function automatic logic [UcsW-1:0] to_ucs2(input logic [WordW-1:0] w,
                                              input logic [1:0] len);
    logic [7:0]      lowb;
    logic [UcsW-1:0] r;
    lowb = {w[9:8], w[5:0]};
    case (len)
      Len1:    r = {8'h00, w[7:0]};
      Len2:    r = {5'b0, w[12:10], lowb};
      Len3:    r = {w[19:16], w[13:10], lowb};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/utf2ucs_ifs.sv
`timescale 1ns / 1ps
`default_nettype none

interface utf2ucs_in_if import utf2ucs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface utf2ucs_out_if import utf2ucs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_char;
  logic             last_of_run;
  logic             string_end;
  logic             bad_sequence;

  modport source (output valid, output out_char, output last_of_run,
                  output string_end, output bad_sequence, input ready);
  modport sink (input valid, input out_char, input last_of_run,
                input string_end, input bad_sequence, output ready);
endinterface

interface utf2ucs_cfg_if import utf2ucs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CapW-1:0] out_capacity;

  modport source (output valid, output out_capacity, input ready);
  modport sink (input valid, input out_capacity, output ready);
endinterface

`default_nettype wire

>>> design/utf8_to_ucs2_hex_text_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  fields                                          words per item
// in_i     in   in_byte[7:0]                                    1
// out_o    out  out_char[7:0] last_of_run string_end bad_seq    0, 1 or 4
// cfg_i    in   out_capacity[14:0]                              1 (ready always high)
//
// a byte that completes a character gives four digit words, one per cycle on out_o while out_o is ready
// bytes that are held or dropped give no word, a marker gives one word
// a taken byte waits in the input register; its words then come from the result register
// in_i stays ready while the result register can take the next byte's words
// reset: no byte pending, out_capacity and budget at 256

module utf8_to_ucs2_hex_text_core import utf2ucs_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf2ucs_in_if.sink    in_i,
  utf2ucs_out_if.source out_o,
  utf2ucs_cfg_if.sink   cfg_i
);

  logic              in_valid_q, in_valid_d;
  logic [ByteW-1:0]  in_byte_q;
  logic [CapW-1:0]   cap_q;
  logic [CapW-1:0]   budget_q, budget_d;
  logic [PendW-1:0]  pw_q, pw_d;
  logic [1:0]        pc_q, pc_d;

  logic              emit_free;
  logic              adv;
  logic              in_acc;
  logic              cfg_acc;
  logic [WordW-1:0]  w;
  logic              term, short, match;
  bundle_t           bundle;

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid;

  assign in_i.ready = !in_valid_q || emit_free;
  assign in_acc     = in_i.valid && in_i.ready;
  assign adv        = in_valid_q && emit_free;

  assign w     = {pw_q, in_byte_q};
  assign term  = (pc_q == Len1) && (in_byte_q == '0);
  assign short = budget_q < MinBudget;

  always_comb begin
    unique case (pc_q)
      Len1:    match = (w >= Win1Lo) && (w <= Win1Hi);
      Len2:    match = (w >= Win2Lo) && (w <= Win2Hi);
      Len3:    match = (w >= Win3Lo) && (w <= Win3Hi);
      default: match = (w >= Win4Lo) && (w <= Win4Hi);
    endcase
  end

  always_comb begin
    bundle.valid   = term || (!short && (match || (pc_q == Len4)));
    bundle.hex     = !term && !short && match;
    bundle.str_end = term;
    bundle.bad     = !term && !short && !match && (pc_q == Len4);
    bundle.ucs     = to_ucs2(w, pc_q);
  end

  always_comb begin
    budget_d = budget_q;
    pw_d     = pw_q;
    pc_d     = pc_q;
    if (cfg_acc) begin
      budget_d = cfg_i.out_capacity;
      pw_d     = '0;
      pc_d     = '0;
    end else if (adv) begin
      if (term) begin
        budget_d = cap_q;
        pw_d     = '0;
      end else if (short) begin
        pw_d = '0;
        pc_d = '0;
      end else if (match) begin
        budget_d = budget_q - CharCost;
        pw_d     = '0;
        pc_d     = '0;
      end else if (pc_q == Len4) begin
        pw_d = '0;
        pc_d = '0;
      end else begin
        pw_d = w[PendW-1:0];
        pc_d = pc_q + 2'd1;
      end
    end
  end

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      cap_q      <= CapReset;
      budget_q   <= CapReset;
      pw_q       <= '0;
      pc_q       <= '0;
    end else begin
      in_valid_q <= in_valid_d;
      budget_q   <= budget_d;
      pw_q       <= pw_d;
      pc_q       <= pc_d;
      if (cfg_acc) begin
        cap_q <= cfg_i.out_capacity;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  utf2ucs_emit u_emit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (adv),
    .bundle_i (bundle),
    .free_o   (emit_free),
    .out_o    (out_o)
  );

  a_budget_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    budget_q <= cap_q)
    else $error("budget above capacity");

  a_marker_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.string_end || out_o.bad_sequence) |->
      out_o.last_of_run && (out_o.out_char == '0))
    else $error("marker word malformed");

  a_marker_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.string_end && out_o.bad_sequence))
    else $error("end and bad flags together");

  a_hold_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !emit_free && !cfg_acc |=> in_valid_q && $stable(in_byte_q))
    else $error("held byte lost");

  a_charge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && bundle.hex && !cfg_acc |=> budget_q == $past(budget_q) - CharCost)
    else $error("character not charged");

endmodule

`default_nettype wire

>>> design/utf2ucs_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module utf2ucs_emit import utf2ucs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  bundle_t              bundle_i,
  output logic                 free_o,
  utf2ucs_out_if.source        out_o
);

  logic            valid_q, valid_d;
  logic            hex_q, end_q, bad_q;
  logic [UcsW-1:0] ucs_q;
  logic [1:0]      idx_q, idx_d;
  logic [3:0]      nib;
  logic            last;

  assign last   = !hex_q || (idx_q == DigitLast);
  assign free_o = !valid_q || (out_o.ready && last);

  always_comb begin
    case (idx_q)
      2'd0:    nib = ucs_q[15:12];
      2'd1:    nib = ucs_q[11:8];
      2'd2:    nib = ucs_q[7:4];
      default: nib = ucs_q[3:0];
    endcase
  end

  assign out_o.valid        = valid_q;
  assign out_o.out_char     = hex_q ? hex_digit(nib) : '0;
  assign out_o.last_of_run  = last;
  assign out_o.string_end   = end_q;
  assign out_o.bad_sequence = bad_q;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = bundle_i.valid;
      idx_d   = '0;
    end else if (valid_q && out_o.ready) begin
      if (last) begin
        valid_d = 1'b0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      hex_q <= bundle_i.hex;
      end_q <= bundle_i.str_end;
      bad_q <= bundle_i.bad;
      ucs_q <= bundle_i.ucs;
    end
  end

endmodule

`default_nettype wire
